// ===== rtl/safp_pkg.sv =====
// Shared types and constants of the sensor advertisement frame parser.
`timescale 1ns / 1ps

package safp_pkg;

    localparam int MAX_FRAME_BYTES = 32;
    localparam int POS_CAP_INT     = (MAX_FRAME_BYTES > 63) ? 63 : MAX_FRAME_BYTES;
    localparam int POS_W           = 6;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

    // Offsets of the bytes that the decoder looks at.
    localparam logic [POS_W-1:0] OFS_REC_TYPE = 6'd11;
    localparam logic [POS_W-1:0] OFS_WORD_A0  = 6'd14;
    localparam logic [POS_W-1:0] OFS_WORD_A1  = 6'd15;
    localparam logic [POS_W-1:0] OFS_WORD_B0  = 6'd16;
    localparam logic [POS_W-1:0] OFS_WORD_B1  = 6'd17;
    localparam logic [POS_W-1:0] LEN_BATT     = 6'd15;
    localparam logic [POS_W-1:0] LEN_SINGLE   = 6'd16;
    localparam logic [POS_W-1:0] LEN_BOTH     = 6'd18;

    localparam logic [15:0] UUID_EXPECTED = 16'hFE95;
    localparam logic [7:0]  FC_BYTE0      = 8'h50;
    localparam logic [7:0]  FC_BYTE1      = 8'h20;
    localparam logic [7:0]  DEV_BYTE0     = 8'hAA;
    localparam logic [7:0]  DEV_BYTE1     = 8'h01;
    localparam logic [7:0]  REC_TEMP      = 8'h04;
    localparam logic [7:0]  REC_HUM       = 8'h06;
    localparam logic [7:0]  REC_BATT      = 8'h0A;
    localparam logic [7:0]  REC_BOTH      = 8'h0D;

    localparam logic [12:0] VOLT_BASE_MV  = 13'd2100;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_INTERVAL = 1'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_OTHER_DEV   = 3'd1,
        STAT_WRONG_UUID  = 3'd2,
        STAT_TOO_SHORT   = 3'd3,
        STAT_BAD_FC      = 3'd4,
        STAT_BAD_TYPE    = 3'd5,
        STAT_UNKNOWN_REC = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_TEMP = 3'd1,
        ACT_HUM  = 3'd2,
        ACT_BATT = 3'd3,
        ACT_BOTH = 3'd4
    } t_action;

    // One classified frame, handed from the front end to the update stage.
    typedef struct packed {
        t_status     status;
        t_action     action;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [31:0] now;
    } t_safp_job;

endpackage

// ===== rtl/safp_front.sv =====
// Front end: gathers frame bytes, checks the frame and classifies its record.
`timescale 1ns / 1ps

module safp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic [47:0]          i_sender_address,
    input  logic [15:0]          i_service_uuid,
    input  logic [31:0]          i_now_seconds,
    input  logic [47:0]          i_device_address,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output safp_pkg::t_safp_job  o_job
);
    import safp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_hdr, n_hdr;
    logic [7:0]       r_type, n_type;
    logic [15:0]      r_wa, n_wa;
    logic [15:0]      r_wb, n_wb;
    logic             accept;
    t_status          status;
    t_action          action;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_pos  = r_pos;
        n_hdr  = r_hdr;
        n_type = r_type;
        n_wa   = r_wa;
        n_wb   = r_wb;
        if (r_pos < POS_CAP) begin
            if (r_pos < POS_W'(4)) begin
                n_hdr[8*r_pos[1:0] +: 8] = i_data_byte;
            end
            if (r_pos == OFS_REC_TYPE) n_type      = i_data_byte;
            if (r_pos == OFS_WORD_A0)  n_wa[7:0]   = i_data_byte;
            if (r_pos == OFS_WORD_A1)  n_wa[15:8]  = i_data_byte;
            if (r_pos == OFS_WORD_B0)  n_wb[7:0]   = i_data_byte;
            if (r_pos == OFS_WORD_B1)  n_wb[15:8]  = i_data_byte;
            n_pos = r_pos + POS_W'(1);
        end
    end

    // n_pos is the frame length when this beat closes the frame.
    always_comb begin
        status = STAT_OK;
        action = ACT_NONE;
        priority if (i_sender_address != i_device_address) begin
            status = STAT_OTHER_DEV;
        end else if (i_service_uuid != UUID_EXPECTED) begin
            status = STAT_WRONG_UUID;
        end else if (n_pos <= OFS_REC_TYPE) begin
            status = STAT_TOO_SHORT;
        end else if (n_hdr[7:0] != FC_BYTE0 || n_hdr[15:8] != FC_BYTE1) begin
            status = STAT_BAD_FC;
        end else if (n_hdr[23:16] != DEV_BYTE0 || n_hdr[31:24] != DEV_BYTE1) begin
            status = STAT_BAD_TYPE;
        end else begin
            unique case (n_type)
                REC_TEMP: begin
                    if (n_pos < LEN_SINGLE) status = STAT_TOO_SHORT;
                    else                    action = ACT_TEMP;
                end
                REC_HUM: begin
                    if (n_pos < LEN_SINGLE) status = STAT_TOO_SHORT;
                    else                    action = ACT_HUM;
                end
                REC_BATT: begin
                    if (n_pos < LEN_BATT) status = STAT_TOO_SHORT;
                    else                  action = ACT_BATT;
                end
                REC_BOTH: begin
                    if (n_pos < LEN_BOTH) status = STAT_TOO_SHORT;
                    else                  action = ACT_BOTH;
                end
                default: status = STAT_UNKNOWN_REC;
            endcase
        end
    end

    assign o_push        = accept && i_last_byte;
    assign o_job.status  = status;
    assign o_job.action  = action;
    assign o_job.word_a  = n_wa;
    assign o_job.word_b  = n_wb;
    assign o_job.now     = i_now_seconds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            r_pos <= i_last_byte ? '0 : n_pos;
        end
    end

    // A short frame never reads bytes it did not write, so these need no clearing.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hdr  <= n_hdr;
            r_type <= n_type;
            r_wa   <= n_wa;
            r_wb   <= n_wb;
        end
    end

endmodule

// ===== rtl/safp_queue.sv =====
// Short register queue of classified frames between the front end and the update stage.
`timescale 1ns / 1ps

module safp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  safp_pkg::t_safp_job  i_job,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output safp_pkg::t_safp_job  o_job
);
    import safp_pkg::*;

    t_safp_job         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] q;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) q = '0;
        else                                q = p + QPTR_W'(1);
        return q;
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + QCNT_W'(1);
            else if (do_pop && !do_push) r_count <= r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_job;
    end

endmodule

// ===== rtl/safp_back.sv =====
// Update stage: applies a classified frame to the stored values and registers the result beat.
`timescale 1ns / 1ps

module safp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  safp_pkg::t_safp_job  i_job,
    output logic                 o_pop,
    input  logic [31:0]          i_notify_interval,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_status,
    output logic [15:0]          o_temperature_tenths,
    output logic [15:0]          o_humidity_tenths,
    output logic [7:0]           o_battery_percent,
    output logic [12:0]          o_voltage_mv,
    output logic                 o_temp_new,
    output logic                 o_humidity_new,
    output logic                 o_battery_new
);
    import safp_pkg::*;

    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic [7:0]  r_batt, n_batt;
    logic [31:0] r_next_t, n_next_t;
    logic [31:0] r_next_h, n_next_h;
    logic [31:0] r_next_b, n_next_b;
    logic        tn, hn, bn;
    logic        due_t, due_h, due_b;
    logic [31:0] next_time;
    logic [12:0] volt;
    logic        r_valid;

    assign o_pop     = !i_empty && (!r_valid || i_ready);
    assign next_time = i_job.now + i_notify_interval;
    assign due_t     = i_job.now > r_next_t;
    assign due_h     = i_job.now > r_next_h;
    assign due_b     = i_job.now > r_next_b;

    always_comb begin
        n_temp   = r_temp;
        n_hum    = r_hum;
        n_batt   = r_batt;
        n_next_t = r_next_t;
        n_next_h = r_next_h;
        n_next_b = r_next_b;
        tn = 1'b0;
        hn = 1'b0;
        bn = 1'b0;
        unique case (i_job.action)
            ACT_TEMP: begin
                tn     = due_t;
                n_temp = i_job.word_a;
            end
            ACT_HUM: begin
                hn    = due_h;
                n_hum = i_job.word_a;
            end
            ACT_BATT: begin
                bn     = due_b;
                n_batt = i_job.word_a[7:0];
            end
            ACT_BOTH: begin
                tn     = due_t;
                hn     = due_h;
                n_temp = i_job.word_a;
                n_hum  = i_job.word_b;
            end
            default: ;
        endcase
        if (tn) n_next_t = next_time;
        if (hn) n_next_h = next_time;
        if (bn) n_next_b = next_time;
    end

    // Ten times the battery byte as two shifted copies.
    assign volt = VOLT_BASE_MV + {2'b0, n_batt, 3'b0} + {4'b0, n_batt, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_temp   <= '0;
            r_hum    <= '0;
            r_batt   <= '0;
            r_next_t <= '0;
            r_next_h <= '0;
            r_next_b <= '0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_temp   <= n_temp;
                r_hum    <= n_hum;
                r_batt   <= n_batt;
                r_next_t <= n_next_t;
                r_next_h <= n_next_h;
                r_next_b <= n_next_b;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_status             <= i_job.status;
            o_temperature_tenths <= n_temp;
            o_humidity_tenths    <= n_hum;
            o_battery_percent    <= n_batt;
            o_voltage_mv         <= volt;
            o_temp_new           <= tn;
            o_humidity_new       <= hn;
            o_battery_new        <= bn;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== rtl/sensor_advert_frame_parser.sv =====
// Top level of the sensor advertisement frame parser.
//
//  channel   direction  handshake                          payload
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata 104 bits, tlast
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata 64 bits
//  cfg       in         i_cfg_wr_en (no wait)              i_cfg_addr, i_cfg_wdata
//
// One byte beat is taken every cycle while the queue has room; the frame check runs on
// the last byte, and its result beat passes through the queue and then the output
// register of the update stage, which handles one frame per cycle unless its output stalls.
// A two-entry queue lets the byte side keep running while a result beat is stalled;
// tready drops only while that queue is full.
// Reset is synchronous and clears the byte counter, the queue, the stored values and
// notify times, and both configuration registers.
`timescale 1ns / 1ps

module sensor_advert_frame_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // data_byte[7:0], sender_address[55:8], service_uuid[71:56], now_seconds[103:72]
    input  logic [103:0]                       i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status[2:0], temperature_tenths[18:3], humidity_tenths[34:19],
    // battery_percent[42:35], voltage_mv[55:43], temp_new[56], humidity_new[57],
    // battery_new[58], zero[63:59]
    output logic [63:0]                        o_m_axis_tdata,
    input  logic                               i_cfg_wr_en,
    input  logic [safp_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [safp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import safp_pkg::*;

    logic [47:0] r_device_address;
    logic [31:0] r_notify_interval;
    logic        push, pop, q_full, q_empty;
    t_safp_job   front_job, back_job;
    logic [2:0]  status;
    logic [15:0] temp, hum;
    logic [7:0]  batt;
    logic [12:0] volt;
    logic        tn, hn, bn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address  <= '0;
            r_notify_interval <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_DEVICE_ADDRESS:  r_device_address  <= i_cfg_wdata[47:0];
                CFG_NOTIFY_INTERVAL: r_notify_interval <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    safp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_data_byte      (i_s_axis_tdata[7:0]),
        .i_last_byte      (i_s_axis_tlast),
        .i_sender_address (i_s_axis_tdata[55:8]),
        .i_service_uuid   (i_s_axis_tdata[71:56]),
        .i_now_seconds    (i_s_axis_tdata[103:72]),
        .i_device_address (r_device_address),
        .i_queue_full     (q_full),
        .o_push           (push),
        .o_job            (front_job)
    );

    safp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (back_job)
    );

    safp_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_empty              (q_empty),
        .i_job                (back_job),
        .o_pop                (pop),
        .i_notify_interval    (r_notify_interval),
        .o_valid              (o_m_axis_tvalid),
        .i_ready              (i_m_axis_tready),
        .o_status             (status),
        .o_temperature_tenths (temp),
        .o_humidity_tenths    (hum),
        .o_battery_percent    (batt),
        .o_voltage_mv         (volt),
        .o_temp_new           (tn),
        .o_humidity_new       (hn),
        .o_battery_new        (bn)
    );

    assign o_m_axis_tdata = {5'b0, bn, hn, tn, volt, batt, hum, temp, status};

endmodule

// ===== rtl/safp_checker.sv =====
// Port-level checks of the frame parser, bound to its top level.
`timescale 1ns / 1ps

module safp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [63:0]                      o_m_axis_tdata
);
    import safp_pkg::*;

    // A pending result beat is not withdrawn.
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // Notify flags only come with an accepted frame.
    a_flags_need_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[58:56] != 3'b000)
        |-> o_m_axis_tdata[2:0] == STAT_OK)
        else $error("notify flag on a rejected frame");

    // The voltage always follows the battery byte that travels with it.
    a_voltage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[55:43] ==
            VOLT_BASE_MV + 13'(o_m_axis_tdata[42:35]) * 13'd10)
        else $error("voltage does not match battery level");

    // Reset leaves no result beat behind.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sensor_advert_frame_parser safp_checker u_safp_checker (.*);
